// File: sv/assert_macros.svh
// Assertion macros shared by the regulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`endif

// File: sv/sdvr_pkg.sv
// Types and constants of the stepped DAC voltage regulator.
`default_nettype none

package sdvr_pkg;

    localparam int unsigned MV_BITS    = 16;
    localparam int unsigned FLOOR_BITS = 12;
    localparam int unsigned STEP_BITS  = 8;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned CFG_IDX_BITS  = 3;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_STEPPED = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GOAL_MV          = 3'd0,
        REG_FLOOR_CODE       = 3'd1,
        REG_STRICT_FLOOR     = 3'd2,
        REG_COARSE_THRESHOLD = 3'd3,
        REG_MEDIUM_THRESHOLD = 3'd4,
        REG_COARSE_STEP      = 3'd5,
        REG_MEDIUM_STEP      = 3'd6,
        REG_FINE_STEP        = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [MV_BITS-1:0]    goal_mv;
        logic [FLOOR_BITS-1:0] floor_code;
        logic                  strict_floor;
        logic [MV_BITS-1:0]    coarse_threshold;
        logic [MV_BITS-1:0]    medium_threshold;
        logic [STEP_BITS-1:0]  coarse_step;
        logic [STEP_BITS-1:0]  medium_step;
        logic [STEP_BITS-1:0]  fine_step;
    } t_sdvr_cfg;

    localparam logic [MV_BITS-1:0]   RST_COARSE_THRESHOLD = 16'd300;
    localparam logic [MV_BITS-1:0]   RST_MEDIUM_THRESHOLD = 16'd100;
    localparam logic [STEP_BITS-1:0] RST_COARSE_STEP      = 8'd30;
    localparam logic [STEP_BITS-1:0] RST_MEDIUM_STEP      = 8'd15;
    localparam logic [STEP_BITS-1:0] RST_FINE_STEP        = 8'd1;

endpackage

`default_nettype wire

// File: sv/sdvr_in_if.sv
// Measurement channel: valid, ready and one measured voltage.
`default_nettype none

interface sdvr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured_mv;

    modport source (output valid, output measured_mv, input ready);
    modport sink   (input valid, input measured_mv, output ready);
endinterface

`default_nettype wire

// File: sv/sdvr_out_if.sv
// Result channel: valid, ready, DAC code and status.
`default_nettype none

interface sdvr_out_if #(
    parameter int unsigned CODE_BITS = 12
);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] dac_code;
    logic [1:0]           status;

    modport source (output valid, output dac_code, output status, input ready);
    modport sink   (input valid, input dac_code, input status, output ready);
endinterface

`default_nettype wire

// File: sv/sdvr_cfg.sv
// Configuration register file of the regulator.
`default_nettype none

module sdvr_cfg
    import sdvr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_data,
    output t_sdvr_cfg                     o_cfg
);

    t_sdvr_cfg r_cfg;
    t_sdvr_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_GOAL_MV:          n_cfg.goal_mv          = i_data;
                REG_FLOOR_CODE:       n_cfg.floor_code       = i_data[FLOOR_BITS-1:0];
                REG_STRICT_FLOOR:     n_cfg.strict_floor     = i_data[0];
                REG_COARSE_THRESHOLD: n_cfg.coarse_threshold = i_data;
                REG_MEDIUM_THRESHOLD: n_cfg.medium_threshold = i_data;
                REG_COARSE_STEP:      n_cfg.coarse_step      = i_data[STEP_BITS-1:0];
                REG_MEDIUM_STEP:      n_cfg.medium_step      = i_data[STEP_BITS-1:0];
                REG_FINE_STEP:        n_cfg.fine_step        = i_data[STEP_BITS-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_mv          <= '0;
            r_cfg.floor_code       <= '0;
            r_cfg.strict_floor     <= 1'b0;
            r_cfg.coarse_threshold <= RST_COARSE_THRESHOLD;
            r_cfg.medium_threshold <= RST_MEDIUM_THRESHOLD;
            r_cfg.coarse_step      <= RST_COARSE_STEP;
            r_cfg.medium_step      <= RST_MEDIUM_STEP;
            r_cfg.fine_step        <= RST_FINE_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/sdvr_step.sv
// Step logic: pick a step size, move the code, saturate and clamp to the floor.
`default_nettype none

module sdvr_step
    import sdvr_pkg::*;
#(
    parameter int unsigned CODE_BITS = 12
) (
    input  wire logic [MV_BITS-1:0]   i_meas,
    input  wire logic [CODE_BITS-1:0] i_code,
    input  wire t_sdvr_cfg            i_cfg,
    output logic      [CODE_BITS-1:0] o_code,
    output t_status                   o_status
);

    localparam int unsigned FW = (CODE_BITS > FLOOR_BITS) ? CODE_BITS : FLOOR_BITS;
    localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};

    logic                 raise;
    logic                 lower;
    logic [MV_BITS-1:0]   err;
    logic [STEP_BITS-1:0] step;
    logic [CODE_BITS:0]   diff;
    logic [CODE_BITS:0]   sum;
    logic [CODE_BITS-1:0] sub_code;
    logic [CODE_BITS-1:0] add_code;
    logic [FW-1:0]        floor_w;
    logic [CODE_BITS-1:0] eff_floor;

    assign raise = i_meas < i_cfg.goal_mv;
    assign lower = i_meas > i_cfg.goal_mv;
    assign err   = raise ? (i_cfg.goal_mv - i_meas) : (i_meas - i_cfg.goal_mv);

    // Thresholds are tested coarse first, even if misordered.
    always_comb begin
        if (err >= i_cfg.coarse_threshold) begin
            step = i_cfg.coarse_step;
        end else if (err >= i_cfg.medium_threshold) begin
            step = i_cfg.medium_step;
        end else begin
            step = i_cfg.fine_step;
        end
    end

    assign diff     = (CODE_BITS+1)'(i_code) - (CODE_BITS+1)'(step);
    assign sum      = (CODE_BITS+1)'(i_code) + (CODE_BITS+1)'(step);
    assign sub_code = diff[CODE_BITS] ? '0 : diff[CODE_BITS-1:0];
    assign add_code = sum[CODE_BITS] ? CODE_MAX : sum[CODE_BITS-1:0];

    // A floor beyond the code range acts as the all-ones code.
    assign floor_w   = FW'(i_cfg.floor_code);
    assign eff_floor = (floor_w > FW'(CODE_MAX)) ? CODE_MAX : CODE_BITS'(floor_w);

    always_comb begin
        o_code   = i_code;
        o_status = ST_NONE;
        if (raise) begin
            if ((i_code == '0) || (i_cfg.strict_floor && (i_code <= eff_floor))) begin
                o_status = ST_LIMIT;
            end else begin
                o_code   = (sub_code < eff_floor) ? eff_floor : sub_code;
                o_status = ST_STEPPED;
            end
        end else if (lower) begin
            if (i_code == CODE_MAX) begin
                o_status = ST_LIMIT;
            end else begin
                o_code   = (add_code < eff_floor) ? eff_floor : add_code;
                o_status = ST_STEPPED;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/stepped_dac_voltage_regulator_top.sv
// Top level of the stepped DAC voltage regulator.
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    measured_mv[15:0]
//  o_out     out  valid / ready    dac_code[CODE_BITS-1:0], status[1:0]
//  i_cfg_*   in   write enable     i_cfg_idx[2:0], i_cfg_data[15:0]
//
// A measurement passes through the input register and then the result
// register. One item per cycle is sustained while o_out.ready stays high;
// the stored code loop closes through the combinational step logic.
// Reset (synchronous, active low) sets the code to all ones and loads the
// register defaults. A stalled output holds the result register, and the
// input register then holds its item; i_in.ready drops only when both are full.
`default_nettype none

`include "assert_macros.svh"

module stepped_dac_voltage_regulator_top
    import sdvr_pkg::*;
#(
    parameter int unsigned CODE_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    sdvr_in_if.sink                       i_in,
    sdvr_out_if.source                    o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_sdvr_cfg cfg;

    // Input stage.
    logic               r_in_valid;
    logic [MV_BITS-1:0] r_meas;

    // Result stage and stored code.
    logic                 r_out_valid;
    logic [CODE_BITS-1:0] r_dac;
    t_status              r_status;
    logic [CODE_BITS-1:0] r_code;

    logic                 n_code_calc;
    logic [CODE_BITS-1:0] n_code;
    t_status              n_status;
    logic                 advance;
    logic                 in_take;

    assign n_code_calc = 1'b1;

    sdvr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sdvr_step #(
        .CODE_BITS (CODE_BITS)
    ) u_step (
        .i_meas   (r_meas),
        .i_code   (r_code),
        .i_cfg    (cfg),
        .o_code   (n_code),
        .o_status (n_status)
    );

    // Move the held item into the result register when that register is free
    // or being drained this cycle.
    assign advance    = r_in_valid && n_code_calc && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Capture the measurement; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_meas <= i_in.measured_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_code      <= {CODE_BITS{1'b1}};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_code      <= n_code;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_dac    <= n_code;
            r_status <= n_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.dac_code = r_dac;
    assign o_out.status   = r_status;

    `ASSERT_IMPLIES(a_out_matches_code, i_clk, i_rst_n, r_out_valid, r_dac == r_code)
    `ASSERT_IMPLIES(a_limit_holds_code, i_clk, i_rst_n, advance && (n_status == ST_LIMIT), n_code == r_code)
    `ASSERT_IMPLIES(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_in.ready)
    `ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

`default_nettype wire
